/* hdl/skt_pkg.sv */
package skt_pkg;

    // One stored key; key_high is the most significant part for ordering.
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_mid;
        logic [31:0] key_low;
    } key_t;

    localparam int unsigned KEY_W = $bits(key_t);
    localparam int unsigned POS_W = 11;

    // Outcome of one probe against one stored entry.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    // Result of one request.
    typedef struct packed {
        logic             full_res;
        logic             inserted;
        logic [POS_W-1:0] position;
        logic             found;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

/* hdl/sorted_key_table_find_insert.sv */
// Channel   Dir  Handshake         Payload
// s_        in   s_tvalid/tready   s_tdata: key_high, key_mid, key_low; s_tuser: action
// m_        out  m_tvalid/tready   m_tdata: found, position, inserted, full_res
//
// A lookup over n entries is a binary search paced by the single read port of
// the key memory (read, then compare, per search step). An insert then moves
// every entry from the insert position upward one slot up (none when the key
// lands past the last entry); the same port moves one entry up per cycle.
// aresetn is synchronous, active low, and empties the table at once.
// s_tready is high only while no request is in progress; a result waiting on
// m_tready does not block the next request, but holds the following result.
module sorted_key_table_find_insert #(
    parameter int unsigned TABLE_SIZE = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // key_high[63:0], key_mid[127:64], key_low[159:128]
    input  logic [0:0]   s_tuser,   // action[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // found[0], position[11:1], inserted[12], full_res[13]
);
    import skt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 1);

    key_t             in_key;
    key_t             probe;
    key_t             mem_wdata;
    key_t             mem_rdata;
    cmp_t             cmp;
    res_t             res;
    res_t             res_reg;
    logic             m_tvalid_reg;
    logic             out_free;
    logic             res_load;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;

    // Unpack the request; key_high sits in the lowest bits of tdata.
    assign in_key.key_high = s_tdata[63:0];
    assign in_key.key_mid  = s_tdata[127:64];
    assign in_key.key_low  = s_tdata[159:128];

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    skt_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[0]),
        .in_key     (in_key),
        .probe      (probe),
        .cmp        (cmp),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    // Key store: one write and one registered read per cycle.
    skt_mem #(
        .DEPTH (TABLE_SIZE),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared comparator for every search step.
    skt_cmp u_cmp (
        .probe  (probe),
        .entry  (mem_rdata),
        .result (cmp)
    );

    // Result register: load on completion, drop on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule

/* hdl/skt_mem.sv */
module skt_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned IDX_W = 10
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  skt_pkg::key_t        wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output skt_pkg::key_t        rdata
);
    import skt_pkg::*;

    key_t mem_reg [DEPTH];
    key_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/skt_cmp.sv */
module skt_cmp (
    input  skt_pkg::key_t probe,
    input  skt_pkg::key_t entry,
    output skt_pkg::cmp_t result
);
    import skt_pkg::*;

    // Unsigned compare over the packed key, high part first.
    always_comb begin
        result.lt = (probe < entry);
        result.eq = (probe == entry);
    end

endmodule

/* hdl/skt_ctrl.sv */
module skt_ctrl #(
    parameter int unsigned TABLE_SIZE = 1024,
    parameter int unsigned IDX_W      = 10,
    parameter int unsigned CNT_W      = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_action,
    input  skt_pkg::key_t        in_key,
    output skt_pkg::key_t        probe,
    input  skt_pkg::cmp_t        cmp,
    output logic                 mem_we,
    output logic [IDX_W-1:0]     mem_waddr,
    output skt_pkg::key_t        mem_wdata,
    output logic                 mem_re,
    output logic [IDX_W-1:0]     mem_raddr,
    input  skt_pkg::key_t        mem_rdata,
    input  logic                 out_free,
    output logic                 res_load,
    output skt_pkg::res_t        res
);
    import skt_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_SIZE);

    state_t           state_reg, state_next;
    key_t             key_reg, key_next;
    logic             act_reg, act_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] src_reg, src_next;
    logic [IDX_W-1:0] waddr_reg, waddr_next;
    logic             wpend_reg, wpend_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic             ins_reg, ins_next;
    logic             full_reg, full_next;

    logic [CNT_W-1:0] mid_calc;
    logic             range_open;
    logic             table_full;
    logic             at_pos;

    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign range_open = (lo_reg < hi_reg);
    assign table_full = (count_reg >= FULL_COUNT);
    assign at_pos     = (src_reg == lo_reg[IDX_W-1:0]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                priority if (range_open) begin
                    state_next = ST_CMP;
                end else if (!act_reg || table_full) begin
                    state_next = ST_DONE;
                end else if (lo_reg == count_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_CMP: begin
                state_next = cmp.eq ? ST_DONE : ST_READ;
            end
            ST_SHIFT: begin
                if (at_pos) begin
                    state_next = ST_SHIFT_LAST;
                end
            end
            ST_SHIFT_LAST: state_next = ST_INSERT;
            ST_INSERT:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        key_next   = key_reg;
        act_next   = act_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        src_next   = src_reg;
        waddr_next = waddr_reg;
        wpend_next = 1'b0;
        count_next = count_reg;
        found_next = found_reg;
        ins_next   = ins_reg;
        full_next  = full_reg;
        mem_we     = 1'b0;
        mem_waddr  = waddr_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = mid_calc[IDX_W-1:0];
        in_ready   = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next   = in_key;
                    act_next   = in_action;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    full_next  = 1'b0;
                end
            end
            ST_READ: begin
                if (range_open) begin
                    mem_re   = 1'b1;
                    mid_next = mid_calc[IDX_W-1:0];
                end else if (act_reg && table_full) begin
                    full_next = 1'b1;
                end else begin
                    // Start the move from the top entry down.
                    src_next = count_reg[IDX_W-1:0] - 1'b1;
                end
            end
            ST_CMP: begin
                priority if (cmp.eq) begin
                    found_next = 1'b1;
                    lo_next    = CNT_W'(mid_reg);
                end else if (cmp.lt) begin
                    hi_next = CNT_W'(mid_reg);
                end else begin
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                end
            end
            ST_SHIFT: begin
                // Read one entry, write the previous one a slot higher.
                mem_re     = 1'b1;
                mem_raddr  = src_reg;
                mem_we     = wpend_reg;
                wpend_next = 1'b1;
                waddr_next = src_reg + 1'b1;
                src_next   = src_reg - 1'b1;
            end
            ST_SHIFT_LAST: begin
                mem_we = 1'b1;
            end
            ST_INSERT: begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[IDX_W-1:0];
                mem_wdata  = key_reg;
                count_next = count_reg + 1'b1;
                ins_next   = 1'b1;
            end
            ST_DONE: begin
                res_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        act_reg   <= act_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        src_reg   <= src_next;
        waddr_reg <= waddr_next;
        found_reg <= found_next;
        ins_reg   <= ins_next;
        full_reg  <= full_next;
    end

    assign probe        = key_reg;
    assign res.found    = found_reg;
    assign res.position = POS_W'(lo_reg);
    assign res.inserted = ins_reg;
    assign res.full_res = full_reg;

endmodule

/* hdl/skt_checker.sv */
module skt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);

    // A stalled result stays offered.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight: ready drops after each accepted request.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A hit never inserts and never reports full.
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[12] && !m_tdata[13])
        else $error("hit reported with insert or full");

    // Insert and refusal are exclusive.
    a_ins_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
        else $error("insert and full both set");

endmodule

bind sorted_key_table_find_insert skt_checker u_skt_checker (.*);
